/* design/depthwise_causal_fir_silu_assert.svh */
// Assertion helpers shared by the design files.
`ifndef DEPTHWISE_CAUSAL_FIR_SILU_ASSERT_SVH
`define DEPTHWISE_CAUSAL_FIR_SILU_ASSERT_SVH

// Check PROP at every rising edge of CLK outside reset.
`define DCFS_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (PROP)) else $error(MSG);

// Check PROP at every rising edge of CLK, reset included.
`define DCFS_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
  LBL: assert property (@(posedge CLK) (PROP)) else $error(MSG);

`endif

/* design/dcfs_pkg.sv */
package dcfs_pkg;

  localparam int DEF_CHANNELS = 1024;
  localparam int DEF_TAPS     = 4;

  localparam int ACC_W     = 54;  // 48-bit products, up to 17 terms
  localparam int SER_TERMS = 16;  // Taylor terms of exp
  localparam int SQ_STEPS  = 3;   // squarings after the series

  typedef struct packed {
    logic               req_type;
    logic [9:0]         chan;
    logic [2:0]         tap_sel;
    logic signed [31:0] coeff_value;
    logic signed [15:0] sample;
    logic               seq_first;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_chan;
    logic signed [15:0] out_value;
    logic               out_saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_CAPTURE, OP_LOAD_WR, OP_SMP_INIT, OP_RD, OP_MUL, OP_ACC,
    OP_RND, OP_TMUL, OP_TSTART, OP_TDONE, OP_EINIT, OP_SQM, OP_SQS, OP_SSTART,
    OP_SDONE, OP_FMUL, OP_FIN, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic chan_ok;
    logic is_load;
    logic term_last;
    logic act_en;
    logic n_last;
    logic sq_last;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD, S_MUL, S_ACC, S_RND, S_TMUL, S_TSTART,
    S_TWAIT, S_EINIT, S_SQM, S_SQS, S_SSTART, S_SWAIT, S_FMUL, S_FIN, S_OUT
  } ctrl_state_t;

endpackage

/* design/dcfs_stream_if.sv */
interface dcfs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/depthwise_causal_fir_silu.sv */
// Channel   | Dir | Payload                                         | Transfer
// in_ch     | in  | req_type chan tap_sel coeff_value sample first  | valid && ready
// out_ch    | out | out_chan out_value out_saturated                | valid && ready
// cfg_ch    | in  | act_enable                                      | valid && ready
//
// After reset the history memory is cleared, with in_ch held off.
// A sample runs through the shared multiplier and accumulator, and when SiLU is on
// through the SiLU unit, where 17 passes of the 64-step
// radix-2 divider (16 series terms and the sigmoid) dominate.
// A result waits in the output register; the next item is taken meanwhile, and a stalled
// out_ch holds the following sample only at its final stage.
module depthwise_causal_fir_silu import dcfs_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int TAPS     = DEF_TAPS
) (
  input logic         clk,
  input logic         rst_n,
  dcfs_stream_if.sink   in_ch,
  dcfs_stream_if.source out_ch,
  dcfs_stream_if.sink   cfg_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  // act_enable is a plain register: always take a transfer
  assign cfg_ch.ready = 1'b1;

  // sequencer: one state per datapath step
  dcfs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .cmd, .sts
  );

  // coefficient and history memories, multiply-accumulate, SiLU unit, output register
  dcfs_dp #(.CHANNELS(CHANNELS), .TAPS(TAPS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_data(in_ch.data),
    .cfg_valid(cfg_ch.valid),
    .cfg_data(cfg_ch.data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_ch.data)
  );
endmodule

/* design/dcfs_ram.sv */
module dcfs_ram #(
  parameter int W = 32,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/dcfs_div.sv */
module dcfs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [31:0] rem_r;
  logic [63:0] q_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, q_r[63]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_r};
  assign ge     = !diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

/* design/dcfs_dp.sv */
`include "depthwise_causal_fir_silu_assert.svh"
module dcfs_dp import dcfs_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int TAPS     = DEF_TAPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int CD   = CHANNELS * (TAPS + 1);
  localparam int HD   = (TAPS > 1) ? CHANNELS * (TAPS - 1) : 1;
  localparam int CA_W = (CD > 1) ? $clog2(CD) : 1;
  localparam int HA_W = (HD > 1) ? $clog2(HD) : 1;
  localparam int TW   = $clog2(TAPS + 1);
  localparam logic signed [ACC_W-1:0] MAX_A = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN_A = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] RND_A = ACC_W'(1) <<< 23;
  localparam logic signed [47:0] MAX_F = 48'(32767);
  localparam logic signed [47:0] MIN_F = -48'(32768);
  localparam logic signed [47:0] RND_F = 48'(1) <<< 29;

  in_item_t                 item_r;
  logic                     act_en_r;
  logic signed [ACC_W-1:0]  acc_r, acc_rnd;
  logic [TW-1:0]            term_r;
  logic [15:0]              prev_r;
  logic signed [47:0]       prod_r, fprod_r, f_rnd;
  logic [HA_W-1:0]          clr_r;
  logic signed [15:0]       x_r, opa;
  logic                     sat_r;
  logic [30:0]              tterm_r, tprod_r, e_r, s_r;
  logic signed [32:0]       sum_r;
  logic [4:0]               n_r;
  logic [61:0]              sq_r;
  logic [1:0]               sq_cnt_r;
  logic                     out_valid_r;
  out_item_t                out_r;
  logic [15:0]              a_mag;
  logic [46:0]              tmul_full;

  logic [CA_W-1:0] cbase, c_waddr, c_raddr, c_sel;
  logic [HA_W-1:0] hbase, h_addr, h_waddr;
  logic [31:0]     c_rdata;
  logic [15:0]     h_rdata, h_wdata, hist_val;
  logic            c_we, h_we, tap_ok, hist_term;

  logic        div_start, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;

  assign tap_ok    = 32'(item_r.tap_sel) <= TAPS;
  assign hist_term = 32'(term_r) >= 2;
  assign cbase     = CA_W'(item_r.chan) * CA_W'(TAPS + 1);
  assign c_sel     = (term_r == '0) ? CA_W'(TAPS) : CA_W'(TAPS) - CA_W'(term_r);
  assign c_we      = (cmd.op == OP_LOAD_WR) && tap_ok;
  assign c_waddr   = cbase + CA_W'(item_r.tap_sel);
  assign c_raddr   = cbase + c_sel;
  assign hbase     = HA_W'(item_r.chan) * HA_W'(TAPS - 1);
  assign h_addr    = hbase + HA_W'(term_r) - HA_W'(2);
  assign h_we      = (cmd.op == OP_CLEAR) || ((cmd.op == OP_MUL) && hist_term);
  assign h_waddr   = (cmd.op == OP_CLEAR) ? clr_r : h_addr;
  assign h_wdata   = (cmd.op == OP_CLEAR) ? '0 :
                     (32'(term_r) == 2) ? item_r.sample : prev_r;
  assign hist_val  = item_r.seq_first ? '0 : h_rdata;

  dcfs_ram #(.W(32), .D(CD)) u_coeff (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(item_r.coeff_value),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  dcfs_ram #(.W(16), .D(HD)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_addr), .rdata(h_rdata)
  );

  always_comb begin
    priority if (term_r == '0) opa = 16'sd4096;
    else if (term_r == TW'(1)) opa = item_r.sample;
    else opa = $signed(hist_val);
  end

  assign acc_rnd   = (acc_r + RND_A) >>> 24;
  assign f_rnd     = (fprod_r + RND_F) >>> 30;
  assign a_mag     = x_r[15] ? 16'(-x_r) : 16'(x_r);
  assign tmul_full = 47'(tterm_r) * 47'(a_mag);

  assign div_start = (cmd.op == OP_TSTART) || (cmd.op == OP_SSTART);
  assign div_dvd   = (cmd.op == OP_TSTART) ? 64'(tprod_r) :
                     x_r[15] ? {3'b0, e_r, 30'b0} : (64'(1) << 60);
  assign div_dvs   = (cmd.op == OP_TSTART) ? 32'(n_r) : (32'(1) << 30) + 32'(e_r);

  dcfs_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_en_r    <= 1'b1;
      clr_r       <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        act_en_r <= cfg_data;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_r <= clr_r + HA_W'(1);
      end
      if (cmd.op == OP_SMP_INIT) begin
        term_r <= '0;
      end else if (cmd.op == OP_ACC) begin
        term_r <= term_r + TW'(1);
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE:  item_r <= in_data;
      OP_SMP_INIT: acc_r <= '0;
      OP_MUL: begin
        prod_r <= opa * $signed(c_rdata);
        prev_r <= hist_val;
      end
      OP_ACC:      acc_r <= acc_r + ACC_W'(prod_r);
      OP_RND: begin
        sat_r    <= (acc_rnd > MAX_A) || (acc_rnd < MIN_A);
        x_r      <= (acc_rnd > MAX_A) ? 16'sh7fff :
                    (acc_rnd < MIN_A) ? 16'sh8000 : acc_rnd[15:0];
        tterm_r  <= 31'(1) << 30;
        sum_r    <= 33'(1) << 30;
        n_r      <= 5'd1;
        sq_cnt_r <= '0;
      end
      OP_TMUL:     tprod_r <= tmul_full[45:15];
      OP_TDONE: begin
        tterm_r <= div_q[30:0];
        sum_r   <= n_r[0] ? sum_r - $signed({2'b0, div_q[30:0]})
                          : sum_r + $signed({2'b0, div_q[30:0]});
        n_r     <= n_r + 5'd1;
      end
      OP_EINIT:    e_r <= sum_r[32] ? '0 : sum_r[30:0];
      OP_SQM:      sq_r <= 62'(e_r) * 62'(e_r);
      OP_SQS: begin
        e_r      <= sq_r[60:30];
        sq_cnt_r <= sq_cnt_r + 2'd1;
      end
      OP_SDONE:    s_r <= div_q[30:0];
      OP_FMUL:     fprod_r <= x_r * $signed({1'b0, s_r});
      OP_FIN:      x_r <= (f_rnd > MAX_F) ? 16'sh7fff :
                          (f_rnd < MIN_F) ? 16'sh8000 : f_rnd[15:0];
      OP_OUT:      out_r <= '{out_chan: item_r.chan, out_value: x_r, out_saturated: sat_r};
      default: ;
    endcase
  end

  always_comb begin
    sts.clr_last  = 32'(clr_r) == HD - 1;
    sts.chan_ok   = 32'(item_r.chan) < CHANNELS;
    sts.is_load   = !item_r.req_type;
    sts.term_last = 32'(term_r) == TAPS;
    sts.act_en    = act_en_r;
    sts.n_last    = n_r == 5'(SER_TERMS);
    sts.sq_last   = sq_cnt_r == 2'(SQ_STEPS - 1);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the last accumulate steps the counter one past the bias-and-taps range
  `DCFS_ASSERT(a_term_bound, clk, rst_n, 32'(term_r) <= TAPS + 1, "tap counter overran")
  `DCFS_ASSERT(a_out_from_op, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.op == OP_OUT), "result raised without output command")
endmodule

/* design/dcfs_ctrl.sv */
`include "depthwise_causal_fir_silu_assert.svh"
module dcfs_ctrl import dcfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.chan_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.is_load) begin
          cmd.op    = OP_LOAD_WR;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SMP_INIT;
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = sts.term_last ? S_RND : S_RD;
      end
      S_RND: begin
        cmd.op    = OP_RND;
        state_nxt = sts.act_en ? S_TMUL : S_OUT;
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TSTART;
      end
      S_TSTART: begin
        cmd.op    = OP_TSTART;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_TDONE;
          state_nxt = sts.n_last ? S_EINIT : S_TMUL;
        end
      end
      S_EINIT: begin
        cmd.op    = OP_EINIT;
        state_nxt = S_SQM;
      end
      S_SQM: begin
        cmd.op    = OP_SQM;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op    = OP_SQS;
        state_nxt = sts.sq_last ? S_SSTART : S_SQM;
      end
      S_SSTART: begin
        cmd.op    = OP_SSTART;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_SDONE;
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.op    = OP_FMUL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `DCFS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> state_r == S_CLEAR, "reset did not start clearing")
  `DCFS_ASSERT(a_out_done, clk, rst_n, (state_r == S_OUT && sts.out_free) |=> state_r == S_IDLE, "result stage did not return to idle")
endmodule
